>>> rtl/core/first_fit_heap_allocator_core_macros.svh
// assertion macros for the allocator core
// they expect signals named clk and rst_n in the calling module
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("allocator check failed");
`define FFHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define FFHA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define FFHA_ASSERT(label, expr)
`define FFHA_ASSERT_IMP(label, ante, cons)
`define FFHA_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> rtl/core/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

    // field widths
    localparam int OFF_W   = 20;
    localparam int SIZE_W  = 21;
    localparam int HEAP_W  = 21;
    localparam int ALLOC_W = 22;
    localparam int VAL_W   = 23;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int HEADER_BYTES   = 16;
    localparam int GRANULE_BYTES  = 16;
    localparam int HEAP_LIMIT     = 1048576;

    // request codes
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT_ISSUE,
        S_FIT_EVAL,
        S_SCAN,
        S_INS_NEW,
        S_INS_PREV,
        S_INS_DONE,
        S_FIND_ISSUE,
        S_FIND_EVAL,
        S_UNLINK,
        S_RS_NEXT,
        S_RS_EVAL,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RESIZE,
        OP_MOVE
    } op_t;

endpackage

>>> rtl/core/ffha_ram.sv
`timescale 1ns / 1ps
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// first-fit heap allocator over an address-ordered block list
// input channel: in_valid / in_stall carry req_type, size_bytes, block_offset,
//   block_given; a beat is taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall carry status, result_offset, moved,
//   old_offset, old_size; exactly one result beat per request beat
// configuration: cfg_valid / cfg_ready write heap_bytes; this clears the list
// one request at a time: in_stall stays high from acceptance until its result
//   has been moved into the output register
// list walks: each linked block is read through the registered ram read port;
//   allocate walks the list, then scans up to MAX_BLOCKS slots for a free one;
//   free walks the list once; a moving resize walks the list three times
// the list lives in one ram, entry word = start, size, link
// reset: empty list, heap size zero, no result pending
// a stalled result holds in the output register; the next request may be
//   accepted meanwhile and waits at its end until the register is free
`include "first_fit_heap_allocator_core_macros.svh"
module first_fit_heap_allocator_core #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ffha_pkg::HEAP_W-1:0] heap_bytes,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic [ffha_pkg::SIZE_W-1:0] size_bytes,
    input  logic [ffha_pkg::OFF_W-1:0]  block_offset,
    input  logic                       block_given,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [ffha_pkg::OFF_W-1:0]  result_offset,
    output logic                       moved,
    output logic [ffha_pkg::OFF_W-1:0]  old_offset,
    output logic [ffha_pkg::SIZE_W-1:0] old_size
);

    localparam int AW     = $clog2(MAX_BLOCKS);
    localparam int IW     = $clog2(MAX_BLOCKS + 1);
    localparam int OW     = ffha_pkg::OFF_W;
    localparam int SW     = ffha_pkg::SIZE_W;
    localparam int VW     = ffha_pkg::VAL_W;
    localparam int WORD_W = OW + SW + IW;
    localparam logic [IW-1:0] END_MARK = IW'(MAX_BLOCKS);
    localparam logic [VW-1:0] HDR = VW'(ffha_pkg::HEADER_BYTES);
    localparam logic [ffha_pkg::ALLOC_W-1:0] GMASK =
        ffha_pkg::ALLOC_W'(ffha_pkg::GRANULE_BYTES - 1);

    // control registers
    ffha_pkg::state_t state_reg, state_next;
    ffha_pkg::op_t    op_reg, op_next;
    logic [ffha_pkg::HEAP_W-1:0] heap_reg, heap_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         count_reg, count_next;
    logic [MAX_BLOCKS-1:0] used_reg, used_next;
    logic                  out_valid_reg, out_valid_next;

    // working registers
    logic [ffha_pkg::ALLOC_W-1:0] alloc_reg, alloc_next;
    logic [VW-1:0] need_reg, need_next;
    logic [OW-1:0] off_reg, off_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [OW-1:0] prev_start_reg, prev_start_next;
    logic [SW-1:0] prev_size_reg, prev_size_next;
    logic [VW-1:0] tail_reg, tail_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [OW-1:0] slot_start_reg, slot_start_next;
    logic [SW-1:0] slot_size_reg, slot_size_next;
    logic [IW-1:0] slot_link_reg, slot_link_next;
    logic [SW-1:0] old_size_reg, old_size_next;
    logic [AW-1:0] scan_reg, scan_next;

    // result staging and output registers
    logic [2:0]    r_status_reg, r_status_next;
    logic [OW-1:0] r_offset_reg, r_offset_next;
    logic          r_moved_reg, r_moved_next;
    logic [OW-1:0] r_old_off_reg, r_old_off_next;
    logic [SW-1:0] r_old_size_reg, r_old_size_next;
    logic [2:0]    status_reg, status_next;
    logic [OW-1:0] offset_reg, offset_next;
    logic          moved_reg, moved_next;
    logic [OW-1:0] old_off_reg, old_off_next;
    logic [SW-1:0] old_sz_reg, old_sz_next;

    // ram port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [OW-1:0]     rd_start;
    logic [SW-1:0]     rd_size;
    logic [IW-1:0]     rd_link;

    logic                         in_acc;
    logic                         out_free;
    logic [ffha_pkg::ALLOC_W-1:0] alloc_in;
    logic [VW-1:0]                fit_sum;
    logic [VW-1:0]                heap_ext;
    logic [VW-1:0]                rd_start_ext;
    logic [VW-1:0]                rs_limit;
    logic [VW-1:0]                rs_sum;
    logic [ffha_pkg::HEAP_W-1:0]  heap_sat;

    ffha_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_BLOCKS)
    ) u_list_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_start = ram_rdata[WORD_W-1 -: OW];
    assign rd_size  = ram_rdata[IW +: SW];
    assign rd_link  = ram_rdata[IW-1:0];

    // handshakes
    assign in_stall  = (state_reg != ffha_pkg::S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == ffha_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // shared arithmetic
    assign alloc_in     = ({1'b0, size_bytes} + GMASK) & ~GMASK;
    assign fit_sum      = tail_reg + need_reg;
    assign heap_ext     = VW'(heap_reg);
    assign rd_start_ext = VW'(rd_start);
    assign rs_limit     = (slot_link_reg == END_MARK) ? heap_ext : rd_start_ext;
    assign rs_sum       = VW'(off_reg) + VW'(alloc_reg);
    assign heap_sat     = (heap_bytes > ffha_pkg::HEAP_W'(ffha_pkg::HEAP_LIMIT)) ?
                          ffha_pkg::HEAP_W'(ffha_pkg::HEAP_LIMIT) : heap_bytes;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        heap_next       = heap_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        alloc_next      = alloc_reg;
        need_next       = need_reg;
        off_next        = off_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_start_next = prev_start_reg;
        prev_size_next  = prev_size_reg;
        tail_next       = tail_reg;
        slot_next       = slot_reg;
        slot_start_next = slot_start_reg;
        slot_size_next  = slot_size_reg;
        slot_link_next  = slot_link_reg;
        old_size_next   = old_size_reg;
        scan_next       = scan_reg;
        r_status_next   = r_status_reg;
        r_offset_next   = r_offset_reg;
        r_moved_next    = r_moved_reg;
        r_old_off_next  = r_old_off_reg;
        r_old_size_next = r_old_size_reg;
        status_next     = status_reg;
        offset_next     = offset_reg;
        moved_next      = moved_reg;
        old_off_next    = old_off_reg;
        old_sz_next     = old_sz_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg[AW-1:0];
        ram_wdata       = {slot_start_reg, slot_size_reg, slot_link_reg};
        ram_raddr       = cur_reg[AW-1:0];

        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    alloc_next      = alloc_in;
                    need_next       = VW'(alloc_in) + HDR;
                    off_next        = block_offset;
                    old_size_next   = '0;
                    r_status_next   = ffha_pkg::ST_OK;
                    r_offset_next   = '0;
                    r_moved_next    = 1'b0;
                    r_old_off_next  = '0;
                    r_old_size_next = '0;
                    tail_next       = '0;
                    prev_next       = END_MARK;
                    cur_next        = head_reg;
                    state_next      = ffha_pkg::S_DONE;
                    if (req_type == ffha_pkg::REQ_ALLOC ||
                        (req_type == ffha_pkg::REQ_RESIZE && !block_given))
                    begin
                        op_next = ffha_pkg::OP_ALLOC;
                        if (alloc_in == '0)
                        begin
                            r_status_next = ffha_pkg::ST_ZERO;
                        end
                        else if (count_reg >= END_MARK)
                        begin
                            r_status_next = ffha_pkg::ST_FULL;
                        end
                        else
                        begin
                            state_next = ffha_pkg::S_FIT_ISSUE;
                        end
                    end
                    else if (req_type == ffha_pkg::REQ_FREE)
                    begin
                        op_next = ffha_pkg::OP_FREE;
                        if (block_given)
                        begin
                            state_next = ffha_pkg::S_FIND_ISSUE;
                        end
                    end
                    else if (req_type == ffha_pkg::REQ_RESIZE)
                    begin
                        op_next    = ffha_pkg::OP_RESIZE;
                        state_next = ffha_pkg::S_FIND_ISSUE;
                    end
                end
            end

            // first-fit walk: gap before cur, or up to heap end
            ffha_pkg::S_FIT_ISSUE:
            begin
                if (cur_reg == END_MARK)
                begin
                    if (heap_ext >= fit_sum)
                    begin
                        scan_next  = '0;
                        state_next = ffha_pkg::S_SCAN;
                    end
                    else
                    begin
                        r_status_next = ffha_pkg::ST_NOFIT;
                        state_next    = ffha_pkg::S_DONE;
                    end
                end
                else
                begin
                    state_next = ffha_pkg::S_FIT_EVAL;
                end
            end

            ffha_pkg::S_FIT_EVAL:
            begin
                if (rd_start_ext >= fit_sum)
                begin
                    scan_next  = '0;
                    state_next = ffha_pkg::S_SCAN;
                end
                else
                begin
                    tail_next       = rd_start_ext + HDR + VW'(rd_size);
                    prev_next       = cur_reg;
                    prev_start_next = rd_start;
                    prev_size_next  = rd_size;
                    cur_next        = rd_link;
                    state_next      = ffha_pkg::S_FIT_ISSUE;
                end
            end

            // look for a free slot, one per cycle
            ffha_pkg::S_SCAN:
            begin
                if (!used_reg[scan_reg])
                begin
                    state_next = ffha_pkg::S_INS_NEW;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ffha_pkg::S_INS_NEW:
            begin
                ram_we              = 1'b1;
                ram_waddr           = scan_reg;
                ram_wdata           = {tail_reg[OW-1:0], alloc_reg[SW-1:0], cur_reg};
                used_next[scan_reg] = 1'b1;
                count_next          = count_reg + 1'b1;
                if (prev_reg == END_MARK)
                begin
                    head_next  = IW'(scan_reg);
                    state_next = ffha_pkg::S_INS_DONE;
                end
                else
                begin
                    state_next = ffha_pkg::S_INS_PREV;
                end
            end

            ffha_pkg::S_INS_PREV:
            begin
                ram_we     = 1'b1;
                ram_waddr  = prev_reg[AW-1:0];
                ram_wdata  = {prev_start_reg, prev_size_reg, IW'(scan_reg)};
                state_next = ffha_pkg::S_INS_DONE;
            end

            ffha_pkg::S_INS_DONE:
            begin
                r_offset_next = OW'(tail_reg + HDR);
                if (op_reg == ffha_pkg::OP_RESIZE)
                begin
                    op_next    = ffha_pkg::OP_MOVE;
                    cur_next   = head_reg;
                    prev_next  = END_MARK;
                    state_next = ffha_pkg::S_FIND_ISSUE;
                end
                else
                begin
                    state_next = ffha_pkg::S_DONE;
                end
            end

            // search for the block by payload offset
            ffha_pkg::S_FIND_ISSUE:
            begin
                if (cur_reg == END_MARK)
                begin
                    if (op_reg == ffha_pkg::OP_MOVE)
                    begin
                        r_moved_next    = 1'b1;
                        r_old_off_next  = off_reg;
                        r_old_size_next = old_size_reg;
                    end
                    else
                    begin
                        r_status_next = ffha_pkg::ST_NOTFOUND;
                    end
                    state_next = ffha_pkg::S_DONE;
                end
                else
                begin
                    state_next = ffha_pkg::S_FIND_EVAL;
                end
            end

            ffha_pkg::S_FIND_EVAL:
            begin
                if (rd_start_ext + HDR == VW'(off_reg))
                begin
                    slot_next       = cur_reg;
                    slot_start_next = rd_start;
                    slot_size_next  = rd_size;
                    slot_link_next  = rd_link;
                    state_next      = (op_reg == ffha_pkg::OP_RESIZE) ?
                                      ffha_pkg::S_RS_NEXT : ffha_pkg::S_UNLINK;
                end
                else
                begin
                    prev_next       = cur_reg;
                    prev_start_next = rd_start;
                    prev_size_next  = rd_size;
                    cur_next        = rd_link;
                    state_next      = ffha_pkg::S_FIND_ISSUE;
                end
            end

            ffha_pkg::S_UNLINK:
            begin
                if (prev_reg == END_MARK)
                begin
                    head_next = slot_link_reg;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_reg[AW-1:0];
                    ram_wdata = {prev_start_reg, prev_size_reg, slot_link_reg};
                end
                used_next[slot_reg[AW-1:0]] = 1'b0;
                count_next = count_reg - 1'b1;
                if (op_reg == ffha_pkg::OP_MOVE)
                begin
                    r_moved_next    = 1'b1;
                    r_old_off_next  = off_reg;
                    r_old_size_next = old_size_reg;
                end
                state_next = ffha_pkg::S_DONE;
            end

            // room up to the next block for an in-place resize
            ffha_pkg::S_RS_NEXT:
            begin
                ram_raddr  = slot_link_reg[AW-1:0];
                state_next = ffha_pkg::S_RS_EVAL;
            end

            ffha_pkg::S_RS_EVAL:
            begin
                if (alloc_reg == '0 || rs_sum <= rs_limit)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = slot_reg[AW-1:0];
                    ram_wdata     = {slot_start_reg, alloc_reg[SW-1:0], slot_link_reg};
                    r_offset_next = off_reg;
                    state_next    = ffha_pkg::S_DONE;
                end
                else
                begin
                    old_size_next = slot_size_reg;
                    if (count_reg >= END_MARK)
                    begin
                        r_status_next = ffha_pkg::ST_FULL;
                        state_next    = ffha_pkg::S_DONE;
                    end
                    else
                    begin
                        tail_next  = '0;
                        prev_next  = END_MARK;
                        cur_next   = head_reg;
                        state_next = ffha_pkg::S_FIT_ISSUE;
                    end
                end
            end

            ffha_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    status_next    = r_status_reg;
                    offset_next    = (r_status_reg == ffha_pkg::ST_OK) ? r_offset_reg : '0;
                    moved_next     = r_moved_reg;
                    old_off_next   = r_old_off_reg;
                    old_sz_next    = r_old_size_reg;
                    out_valid_next = 1'b1;
                    state_next     = ffha_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase

        // configuration write clears the list
        if (cfg_valid && cfg_ready)
        begin
            heap_next  = heap_sat & ~ffha_pkg::HEAP_W'(ffha_pkg::GRANULE_BYTES - 1);
            head_next  = END_MARK;
            count_next = '0;
            used_next  = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::S_IDLE;
            heap_reg      <= '0;
            head_reg      <= END_MARK;
            count_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_reg      <= heap_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        alloc_reg      <= alloc_next;
        need_reg       <= need_next;
        off_reg        <= off_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_start_reg <= prev_start_next;
        prev_size_reg  <= prev_size_next;
        tail_reg       <= tail_next;
        slot_reg       <= slot_next;
        slot_start_reg <= slot_start_next;
        slot_size_reg  <= slot_size_next;
        slot_link_reg  <= slot_link_next;
        old_size_reg   <= old_size_next;
        scan_reg       <= scan_next;
        r_status_reg   <= r_status_next;
        r_offset_reg   <= r_offset_next;
        r_moved_reg    <= r_moved_next;
        r_old_off_reg  <= r_old_off_next;
        r_old_size_reg <= r_old_size_next;
        status_reg     <= status_next;
        offset_reg     <= offset_next;
        moved_reg      <= moved_next;
        old_off_reg    <= old_off_next;
        old_sz_reg     <= old_sz_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_offset = offset_reg;
    assign moved         = moved_reg;
    assign old_offset    = old_off_reg;
    assign old_size      = old_sz_reg;

    // checks
    `FFHA_ASSERT(a_count_max, count_reg <= END_MARK)
    `FFHA_ASSERT(a_count_used, $countones(used_reg) == int'(count_reg))
    `FFHA_ASSERT(a_head_empty, (head_reg == END_MARK) == (count_reg == '0))
    `FFHA_ASSERT_NXT(a_done_loads, state_reg == ffha_pkg::S_DONE && out_free, out_valid_reg && state_reg == ffha_pkg::S_IDLE)
    `FFHA_ASSERT_IMP(a_moved_ok, out_valid_reg && moved_reg, status_reg == ffha_pkg::ST_OK)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int MAXB = ffha_pkg::MAX_BLOCKS_DEF;
    localparam int END_LINK = MAXB;
    localparam int OW = ffha_pkg::OFF_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam int HW = ffha_pkg::HEAP_W;
    localparam int HDR_B = ffha_pkg::HEADER_BYTES;
    localparam int GRAN_B = ffha_pkg::GRANULE_BYTES;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SIZE_MAX = (1 << SW) - 1;
    localparam int OFF_MAX = (1 << OW) - 1;

    typedef struct packed {
        logic [2:0]    status;
        logic [OW-1:0] result_offset;
        logic          moved;
        logic [OW-1:0] old_offset;
        logic [SW-1:0] old_size;
    } alloc_result_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [HW-1:0] heap_bytes;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic [SW-1:0] size_bytes;
    logic [OW-1:0] block_offset;
    logic block_given;
    logic out_valid;
    logic out_stall;
    logic [2:0] status;
    logic [OW-1:0] result_offset;
    logic moved;
    logic [OW-1:0] old_offset;
    logic [SW-1:0] old_size;

    // shadow of the block list
    int unsigned blk_start [MAXB];
    int unsigned blk_size [MAXB];
    int unsigned blk_link [MAXB];
    bit blk_live [MAXB];
    int unsigned list_first;
    int unsigned live_blocks;
    int unsigned heap_limit;

    alloc_result_t awaited_results [$];
    int error_count;
    int idle_pct;
    int stall_pct;
    int hold_request;
    int hold_cnt;
    int quiet_cycles;

    first_fit_heap_allocator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .heap_bytes(heap_bytes),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .size_bytes(size_bytes), .block_offset(block_offset), .block_given(block_given),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .result_offset(result_offset), .moved(moved), .old_offset(old_offset),
        .old_size(old_size)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic void clear_list();
        for (int i = 0; i < MAXB; i++)
        begin
            blk_live[i] = 1'b0;
            blk_link[i] = END_LINK;
        end
        list_first = END_LINK;
        live_blocks = 0;
    endfunction

    function automatic int unsigned lookup_block(input longint unsigned off,
                                                 output int unsigned prv);
        int unsigned cur;
        int unsigned p;
        cur = list_first;
        p = END_LINK;
        prv = END_LINK;
        for (int s = 0; s <= MAXB && cur < MAXB; s++)
        begin
            if (longint'(blk_start[cur]) + HDR_B == off)
            begin
                prv = p;
                return cur;
            end
            p = cur;
            cur = blk_link[cur];
        end
        return END_LINK;
    endfunction

    function automatic logic [2:0] place_first_fit(input longint unsigned alloc,
                                                   output longint unsigned off);
        longint unsigned need;
        longint unsigned tail;
        longint unsigned lim;
        int unsigned p;
        int unsigned nx;
        int k;
        need = alloc + HDR_B;
        tail = 0;
        p = END_LINK;
        nx = list_first;
        off = 0;
        if (live_blocks >= MAXB)
            return ffha_pkg::ST_FULL;
        for (int s = 0; s <= MAXB; s++)
        begin
            lim = (nx < MAXB) ? longint'(blk_start[nx]) : longint'(heap_limit);
            if (lim >= tail && lim - tail >= need)
            begin
                for (k = 0; k < MAXB; k++)
                    if (!blk_live[k])
                        break;
                if (k >= MAXB)
                    return ffha_pkg::ST_FULL;
                blk_live[k] = 1'b1;
                blk_start[k] = 32'(tail);
                blk_size[k] = 32'(alloc);
                blk_link[k] = nx;
                if (p < MAXB)
                    blk_link[p] = k;
                else
                    list_first = k;
                live_blocks++;
                off = tail + HDR_B;
                return ffha_pkg::ST_OK;
            end
            if (nx >= MAXB)
                break;
            tail = longint'(blk_start[nx]) + HDR_B + longint'(blk_size[nx]);
            p = nx;
            nx = blk_link[nx];
        end
        return ffha_pkg::ST_NOFIT;
    endfunction

    function automatic void unlink_block(input int unsigned slot, input int unsigned prv);
        if (prv < MAXB)
            blk_link[prv] = blk_link[slot];
        else
            list_first = blk_link[slot];
        blk_live[slot] = 1'b0;
        if (live_blocks > 0)
            live_blocks--;
    endfunction

    // expected outcome of one request, updating the shadow list
    function automatic alloc_result_t predict_request(input logic [1:0] rq,
            input logic [SW-1:0] sz, input logic [OW-1:0] off, input logic given);
        alloc_result_t r;
        longint unsigned alloc;
        longint unsigned res;
        longint unsigned lim;
        longint unsigned room;
        longint unsigned osz;
        int unsigned slot;
        int unsigned prv;
        int unsigned nx;
        r = '0;
        res = 0;
        alloc = ((longint'(sz) + GRAN_B - 1) / GRAN_B) * GRAN_B;
        if (rq == ffha_pkg::REQ_ALLOC || (rq == ffha_pkg::REQ_RESIZE && !given))
        begin
            if (alloc == 0)
                r.status = ffha_pkg::ST_ZERO;
            else
                r.status = place_first_fit(alloc, res);
        end
        else if (rq == ffha_pkg::REQ_FREE)
        begin
            if (given)
            begin
                slot = lookup_block(longint'(off), prv);
                if (slot < MAXB)
                    unlink_block(slot, prv);
                else
                    r.status = ffha_pkg::ST_NOTFOUND;
            end
        end
        else if (rq == ffha_pkg::REQ_RESIZE)
        begin
            slot = lookup_block(longint'(off), prv);
            if (slot >= MAXB)
                r.status = ffha_pkg::ST_NOTFOUND;
            else
            begin
                nx = blk_link[slot];
                lim = (nx < MAXB) ? longint'(blk_start[nx]) : longint'(heap_limit);
                room = (lim >= longint'(off)) ? lim - longint'(off) : 0;
                if (alloc <= room)
                begin
                    blk_size[slot] = 32'(alloc);
                    res = longint'(off);
                end
                else
                begin
                    osz = longint'(blk_size[slot]);
                    r.status = place_first_fit(alloc, res);
                    if (r.status == ffha_pkg::ST_OK)
                    begin
                        slot = lookup_block(longint'(off), prv);
                        if (slot < MAXB)
                            unlink_block(slot, prv);
                        r.moved = 1'b1;
                        r.old_offset = off;
                        r.old_size = SW'(osz);
                    end
                end
            end
        end
        if (r.status == ffha_pkg::ST_OK)
            r.result_offset = OW'(res);
        return r;
    endfunction

    // payload offset of a random live block, or a random offset when empty
    function automatic logic [OW-1:0] pick_live_offset();
        int unsigned cur;
        int n;
        cur = list_first;
        if (live_blocks == 0)
            return OW'($urandom_range(0, OFF_MAX));
        n = int'($urandom_range(0, live_blocks - 1));
        for (int i = 0; i < n && cur < MAXB; i++)
            cur = blk_link[cur];
        return OW'(blk_start[cur] + HDR_B);
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint exp);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, exp, $realtime);
        error_count++;
    endtask

    // send one request beat, keeping valid high for a following beat
    task automatic send_request(input logic [1:0] rq, input logic [SW-1:0] sz,
                                input logic [OW-1:0] off, input logic given);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        size_bytes <= sz;
        block_offset <= off;
        block_given <= given;
        do
            @(posedge clk);
        while (in_stall);
        awaited_results.push_back(predict_request(rq, sz, off, given));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_size(input logic [HW-1:0] v);
        int unsigned lim;
        drain_results();
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        heap_bytes <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        lim = 32'(v);
        if (lim > ffha_pkg::HEAP_LIMIT)
            lim = ffha_pkg::HEAP_LIMIT;
        heap_limit = (lim / GRAN_B) * GRAN_B;
        clear_list();
    endtask

    // random request, biased towards valid frees and resizes of live blocks
    task automatic send_random_request();
        int r;
        logic [SW-1:0] sz;
        r = int'($urandom_range(0, 99));
        sz = ($urandom_range(0, 19) == 0) ? SW'($urandom_range(0, SIZE_MAX))
                                          : SW'($urandom_range(0, 300));
        if (r < 45)
            send_request(ffha_pkg::REQ_ALLOC, sz, OW'($urandom_range(0, OFF_MAX)),
                         1'($urandom_range(0, 1)));
        else if (r < 72)
            send_request(ffha_pkg::REQ_FREE, sz, pick_live_offset(), 1'b1);
        else if (r < 90)
            send_request(ffha_pkg::REQ_RESIZE, sz, pick_live_offset(), 1'b1);
        else
            send_request(2'($urandom_range(0, 3)), sz, OW'($urandom_range(0, OFF_MAX)),
                         1'($urandom_range(0, 1)));
    endtask

    task automatic test_heap_size_extremes();
        write_heap_size('0);
        send_request(ffha_pkg::REQ_ALLOC, 21'd1, '0, 1'b0);
        write_heap_size(21'd17);
        send_request(ffha_pkg::REQ_ALLOC, 21'd0, '0, 1'b0);
        send_request(ffha_pkg::REQ_ALLOC, 21'd1, '0, 1'b0);
        write_heap_size(21'd48);
        send_request(ffha_pkg::REQ_ALLOC, 21'd16, '0, 1'b0);
        send_request(ffha_pkg::REQ_ALLOC, 21'd1, '0, 1'b0);
        write_heap_size(21'h1FFFFF);
        send_request(ffha_pkg::REQ_ALLOC, 21'h1FFFFF, 20'hFFFFF, 1'b1);
        send_request(ffha_pkg::REQ_ALLOC, 21'd1048560, '0, 1'b0);
        send_request(ffha_pkg::REQ_FREE, '0, 20'd16, 1'b1);
        drain_results();
    endtask

    task automatic test_each_request();
        write_heap_size(21'd1024);
        send_request(ffha_pkg::REQ_ALLOC, 21'd20, '0, 1'b0);
        send_request(ffha_pkg::REQ_ALLOC, 21'd16, '0, 1'b0);
        send_request(ffha_pkg::REQ_RESIZE, 21'd33, '0, 1'b0);
        send_request(ffha_pkg::REQ_FREE, '0, 20'd999, 1'b0);
        send_request(ffha_pkg::REQ_FREE, '0, 20'd40, 1'b1);
        send_request(ffha_pkg::REQ_RESIZE, 21'd8, 20'd40, 1'b1);
        send_request(ffha_pkg::REQ_RESIZE, 21'd0, 20'd64, 1'b1);
        send_request(ffha_pkg::REQ_RESIZE, 21'd16, 20'd64, 1'b1);
        send_request(ffha_pkg::REQ_RESIZE, 21'd200, 20'd16, 1'b1);
        send_request(ffha_pkg::REQ_RESIZE, 21'h1FFFFF, 20'd64, 1'b1);
        send_request(REQ_UNKNOWN, 21'h1FFFFF, 20'hFFFFF, 1'b1);
        send_request(ffha_pkg::REQ_FREE, '0, 20'd64, 1'b1);
        send_request(ffha_pkg::REQ_ALLOC, 21'd1, '0, 1'b0);
        drain_results();
    endtask

    task automatic test_table_full();
        write_heap_size(21'd1048576);
        for (int i = 0; i <= MAXB; i++)
            send_request(ffha_pkg::REQ_ALLOC, 21'd1, '0, 1'b0);
        send_request(ffha_pkg::REQ_RESIZE, 21'd500, 20'd16, 1'b1);
        send_request(ffha_pkg::REQ_FREE, '0, 20'd16, 1'b1);
        send_request(ffha_pkg::REQ_ALLOC, 21'd1, '0, 1'b0);
        send_request(ffha_pkg::REQ_ALLOC, 21'd1, '0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int heaps [5];
        heaps = '{1024, 4096, 65536, 1048576, 0};
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 50) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 50) : 0;
            for (int h = 0; h < 5; h++)
            begin
                write_heap_size((h == 4) ? HW'($urandom_range(0, SIZE_MAX)) : HW'(heaps[h]));
                repeat (75) send_random_request();
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_heap_size(21'd4096);
        hold_request = 400;
        repeat (30) send_random_request();
        drain_results();
        repeat (20) send_random_request();
        drain_results();
    endtask

    // result sink with random and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (hold_request != 0)
            begin
                hold_cnt = hold_request;
                hold_request = 0;
            end
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("unexpected beat", 1, 0);
            end
            else
            begin
                e = awaited_results.pop_front();
                if (status !== e.status)
                    report_mismatch("status", status, e.status);
                if (result_offset !== e.result_offset)
                    report_mismatch("result_offset", result_offset, e.result_offset);
                if (moved !== e.moved)
                    report_mismatch("moved", moved, e.moved);
                if (old_offset !== e.old_offset)
                    report_mismatch("old_offset", old_offset, e.old_offset);
                if (old_size !== e.old_size)
                    report_mismatch("old_size", old_size, e.old_size);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        heap_bytes = '0;
        in_valid = 1'b0;
        req_type = ffha_pkg::REQ_ALLOC;
        size_bytes = '0;
        block_offset = '0;
        block_given = 1'b0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 0;
        quiet_cycles = 0;
        heap_limit = 0;
        clear_list();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_heap_size_extremes();
        test_each_request();
        test_table_full();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/first_fit_heap_allocator_core.sv
tb/tb_top.sv
